[design/byte_stuffing_deframer_assert.svh]
// ----------------------------------------------------------------------------
// byte stuffing deframer assertion macros
// shared property forms for the deframer checks
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_DEFRAMER_ASSERT_SVH
`define BYTE_STUFFING_DEFRAMER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg
// shared types and constants of the byte stuffing deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsd_pkg;

    // largest number of payload bytes stored per frame
    localparam int MAX_FRAME_BYTES = 64;
    // width of the stored byte count and of the frame_length port
    localparam int LEN_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

    // reset values of the code registers
    localparam logic [BYTE_W-1:0] START_RESET  = 8'd15;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd4;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd5;

    // start codes needed to open a frame
    localparam logic [1:0] START_PAIR = 2'd2;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_ACCEPT  = 2'd1,
        EV_REJECT  = 2'd2,
        EV_ABORT   = 2'd3
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] stop_code;
        logic [BYTE_W-1:0] escape_code;
    } codes_t;

    typedef struct packed {
        logic              has;
        event_t            ev;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } result_t;

endpackage

[design/bsd_core.sv]
// ----------------------------------------------------------------------------
// bsd_core
// frame state and per-byte unstuffing step of the deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [bsd_pkg::BYTE_W-1:0] rx_data,
    input  bsd_pkg::codes_t            codes,
    output bsd_pkg::result_t           result
);
    import bsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME_BYTES);

    phase_t            phase_reg, phase_next;
    logic [1:0]        starts_reg, starts_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [1:0]        hunt_starts;
    logic [BYTE_W-1:0] sum_add;
    logic              room;

    assign sum_add = sum_reg + rx_data;
    assign room    = (count_reg < LEN_LIMIT);

    // start pair countdown while hunting
    always_comb
    begin
        if (rx_data == codes.start_code)
        begin
            hunt_starts = (starts_reg != 2'd0) ? (starts_reg - 2'd1) : starts_reg;
        end
        else
        begin
            hunt_starts = START_PAIR;
        end
    end

    // next state and result for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        starts_next = starts_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        result      = '0;
        result.ev   = EV_PAYLOAD;
        unique case (phase_reg)
            PH_HUNT:
            begin
                starts_next = hunt_starts;
                if (hunt_starts == 2'd0)
                begin
                    phase_next = PH_FRAME;
                    sum_next   = '0;
                    count_next = '0;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_FRAME;
                sum_next   = sum_add;
                if (room)
                begin
                    count_next  = count_reg + 1'b1;
                    result.has  = 1'b1;
                    result.data = rx_data;
                end
            end
            PH_FRAME:
            begin
                priority if (rx_data == codes.stop_code)
                begin
                    result.has  = 1'b1;
                    result.ev   = (sum_reg == '0 && count_reg != '0) ? EV_ACCEPT : EV_REJECT;
                    result.len  = count_reg;
                    result.last = 1'b1;
                    phase_next  = PH_HUNT;
                    starts_next = START_PAIR;
                end
                else if (rx_data == codes.start_code)
                begin
                    result.has  = 1'b1;
                    result.ev   = EV_ABORT;
                    result.len  = count_reg;
                    result.last = 1'b1;
                    phase_next  = PH_HUNT;
                    starts_next = 2'd1;
                end
                else if (rx_data == codes.escape_code)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    sum_next = sum_add;
                    if (room)
                    begin
                        count_next  = count_reg + 1'b1;
                        result.has  = 1'b1;
                        result.data = rx_data;
                    end
                end
            end
            default:
            begin
                phase_next  = PH_HUNT;
                starts_next = START_PAIR;
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            starts_reg <= START_PAIR;
            sum_reg    <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            starts_reg <= starts_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/byte_stuffing_deframer.sv]
// ----------------------------------------------------------------------------
// byte_stuffing_deframer
// Receives raw bytes on rx_byte (rx_valid / rx_stall) and finds frames opened
// by two start codes and closed by the stop code; an escape code makes the
// next byte literal. Each stored payload byte comes out on the result channel
// (res_valid / res_stall) as event_res payload; frame end gives accept or
// reject with frame_length and last, a start code inside a frame gives abort.
// Codes are set over cfg_valid / cfg_ready / cfg_index / cfg_data (index 0
// start, 1 stop, 2 escape); the user must set them only while no byte is in
// flight, which the block does not enforce; cfg_ready is always high. A byte
// passes an input register, then the step logic into the result register.
// One byte per cycle is sustained while no result waits on res_stall, set by
// the single state update per byte; bytes that give no result take a step too.
// While res_stall is high a waiting result holds, and the input register
// still takes a byte whenever it is empty or can move on.
// Reset hunts for a start pair, with codes 15, 4 and 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_stuffing_deframer_assert.svh"

module byte_stuffing_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_stall,
    input  logic [bsd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [1:0]                    event_res,
    output logic [bsd_pkg::BYTE_W-1:0]    payload_byte,
    output logic [bsd_pkg::LEN_W-1:0]     frame_length,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsd_pkg::BYTE_W-1:0]    cfg_data
);
    import bsd_pkg::*;

    codes_t            codes_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           step_res;
    logic              advance;
    logic              take_in;

    // input register moves on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !res_stall);
    assign take_in  = rx_valid && !rx_stall;
    assign rx_stall = in_valid_reg && !advance;

    assign cfg_ready = 1'b1;

    // code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code  <= START_RESET;
            codes_reg.stop_code   <= STOP_RESET;
            codes_reg.escape_code <= ESCAPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START:  codes_reg.start_code  <= cfg_data;
                REG_STOP:   codes_reg.stop_code   <= cfg_data;
                REG_ESCAPE: codes_reg.escape_code <= cfg_data;
                default:    codes_reg             <= codes_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in || advance)
        begin
            in_valid_reg <= take_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // per-byte step and frame state
    bsd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_data (in_byte_reg),
        .codes   (codes_reg),
        .result  (step_res)
    );

    // result register valid
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = step_res.has;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && step_res.has)
        begin
            out_reg <= step_res;
        end
    end

    assign res_valid    = out_valid_reg;
    assign event_res    = out_reg.ev;
    assign payload_byte = out_reg.data;
    assign frame_length = out_reg.len;
    assign last         = out_reg.last;

    // checks
    `BSD_ASSERT_NOW(a_free_output_drains_input, in_valid_reg && !out_valid_reg, !rx_stall,
        "input stalled while result register is free")
    `BSD_ASSERT_NOW(a_length_bounded, res_valid, frame_length <= LEN_W'(MAX_FRAME_BYTES),
        "frame length beyond limit")
    `BSD_ASSERT_NOW(a_payload_not_last, res_valid && event_res == EV_PAYLOAD,
        !last && frame_length == '0, "payload request marked as frame end")
    `BSD_ASSERT_NEXT(a_stalled_result_held, res_valid && res_stall, res_valid,
        "stalled result dropped")

endmodule
